/* hdl/atam_pkg.sv */
// ---------------------------------------------------------------------------
// atam_pkg : shared types and constants of the step / tilt / activity monitor
// Register indexes, reset levels, serial step count and the structs that
// carry configuration and results between the modules.
// ---------------------------------------------------------------------------
`default_nettype none

package atam_pkg;

  // Fixed-point format of the samples
  localparam int unsigned FracBits = 12;
  localparam logic [15:0] OneG     = 16'(1 << FracBits);

  // Default inactivity minute length in samples (80 ms ticks)
  localparam int unsigned SamplesPerMinute = 750;

  // Serial units: 16 multiplier bits, 16 root digits of two bits
  localparam int unsigned SerialSteps = 16;
  localparam int unsigned CntW        = $clog2(SerialSteps);

  // Register indexes on the configuration port
  localparam int unsigned CfgAddrW = 3;
  localparam logic [CfgAddrW-1:0] RegStepOn   = 3'd0;
  localparam logic [CfgAddrW-1:0] RegStepOff  = 3'd1;
  localparam logic [CfgAddrW-1:0] RegTiltOn   = 3'd2;
  localparam logic [CfgAddrW-1:0] RegTiltOff  = 3'd3;
  localparam logic [CfgAddrW-1:0] RegMotion   = 3'd4;
  localparam logic [CfgAddrW-1:0] RegStill    = 3'd5;
  localparam logic [CfgAddrW-1:0] RegDebounce = 3'd6;

  // Register reset values
  localparam logic [15:0] StepOnReset   = 16'd5120;
  localparam logic [15:0] StepOffReset  = 16'd4710;
  localparam logic [15:0] TiltOnReset   = 16'd2867;
  localparam logic [15:0] TiltOffReset  = 16'd2048;
  localparam logic [15:0] MotionReset   = 16'd1229;
  localparam logic [15:0] StillReset    = 16'd205;
  localparam logic [7:0]  DebounceReset = 8'd3;

  // Sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StSquare,
    StLoad,
    StRoot,
    StCommit
  } atam_state_e;

  // Configuration registers
  typedef struct packed {
    logic        [15:0] step_on;
    logic        [15:0] step_off;
    logic signed [15:0] tilt_on;
    logic signed [15:0] tilt_off;
    logic        [15:0] motion;
    logic        [15:0] still;
    logic        [7:0]  debounce;
  } atam_cfg_t;

  // One result
  typedef struct packed {
    logic [31:0] step_total;
    logic        step_seen;
    logic        wake_pulse;
    logic        is_moving;
    logic [31:0] inactive_samples;
    logic [22:0] inactive_minutes;
  } atam_res_t;

  // Magnitude of a signed 16-bit sample; the most negative value gives 32768
  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    logic [15:0] r;
    r = v[15] ? 16'(-v) : 16'(v);
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/atam_sqr.sv */
// ---------------------------------------------------------------------------
// atam_sqr : bit-serial squarer
// Shift-add multiply of an unsigned 16-bit value by itself, one multiplier
// bit per step; the result is ready after sixteen steps.
// ---------------------------------------------------------------------------
`default_nettype none

module atam_sqr (
  input  wire logic        clk_i,
  input  wire logic        load_i,
  input  wire logic        step_i,
  input  wire logic [15:0] operand_i,
  output logic      [31:0] square_o
);
  import atam_pkg::*;

  logic [15:0] mcand_q, mcand_d;
  logic [31:0] prod_q, prod_d;
  logic [16:0] hi_sum;

  // Add the multiplicand into the upper half when the low bit is set
  always_comb begin
    hi_sum  = {1'b0, prod_q[31:16]} + (prod_q[0] ? {1'b0, mcand_q} : 17'd0);
    mcand_d = mcand_q;
    prod_d  = prod_q;
    if (load_i) begin
      mcand_d = operand_i;
      prod_d  = {16'd0, operand_i};
    end else if (step_i) begin
      prod_d = {hi_sum, prod_q[15:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q <= mcand_d;
    prod_q  <= prod_d;
  end

  assign square_o = prod_q;

endmodule

`default_nettype wire

/* hdl/atam_isqrt.sv */
// ---------------------------------------------------------------------------
// atam_isqrt : digit-serial integer square root
// Restoring root of a 32-bit radicand, two radicand bits per step; gives the
// floor root after sixteen steps.
// ---------------------------------------------------------------------------
`default_nettype none

module atam_isqrt (
  input  wire logic        clk_i,
  input  wire logic        load_i,
  input  wire logic        step_i,
  input  wire logic [31:0] radicand_i,
  output logic      [15:0] root_o
);
  import atam_pkg::*;

  logic [31:0] rad_q, rad_d;
  logic [16:0] rem_q, rem_d;
  logic [15:0] root_q, root_d;
  logic [18:0] rem_cat;
  logic [18:0] trial;
  logic        fits;

  // One root digit: bring down two bits, try 4*root+1
  always_comb begin
    rem_cat = {rem_q, rad_q[31:30]};
    trial   = {1'b0, root_q, 2'b01};
    fits    = (rem_cat >= trial);
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    if (load_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
    end else if (step_i) begin
      rad_d  = {rad_q[29:0], 2'b00};
      rem_d  = fits ? 17'(rem_cat - trial) : rem_cat[16:0];
      root_d = {root_q[14:0], fits};
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o = root_q;

endmodule

`default_nettype wire

/* hdl/atam_track.sv */
// ---------------------------------------------------------------------------
// atam_track : step, wrist-up and stillness trackers
// Works out the next tracker state from the magnitude and the Y sample and
// keeps it on commit; the still count carries a minute counter beside it.
// ---------------------------------------------------------------------------
`default_nettype none

module atam_track #(
  parameter int unsigned SAMPLES_PER_MINUTE = atam_pkg::SamplesPerMinute
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire atam_pkg::atam_cfg_t       cfg_i,
  input  wire logic               [15:0] mag_i,
  input  wire logic signed        [15:0] accel_y_i,
  input  wire logic                      clear_i,
  input  wire logic                      commit_i,
  output atam_pkg::atam_res_t            res_o
);
  import atam_pkg::*;

  localparam int unsigned SubW = (SAMPLES_PER_MINUTE > 1) ? $clog2(SAMPLES_PER_MINUTE) : 1;
  localparam logic [SubW-1:0] SubLast = SubW'(SAMPLES_PER_MINUTE - 1);

  logic            step_high_q, step_high_d;
  logic            wrist_q, wrist_d;
  logic [31:0]     steps_q, steps_d;
  logic [7:0]      since_q, since_d;
  logic [31:0]     still_q, still_d;
  logic [SubW-1:0] sub_q, sub_d;
  logic [22:0]     mins_q, mins_d;
  logic            step_now, wake_now, moving;
  logic [15:0]     dev;

  always_comb begin
    step_high_d = step_high_q;
    wrist_d     = wrist_q;
    steps_d     = clear_i ? 32'd0 : steps_q;
    since_d     = (since_q == 8'hFF) ? since_q : since_q + 8'd1;
    still_d     = still_q;
    sub_d       = sub_q;
    mins_d      = mins_q;
    step_now    = 1'b0;
    wake_now    = 1'b0;

    // Step detector with debounce and hysteresis
    if (!step_high_q && (mag_i > cfg_i.step_on)) begin
      if (since_d > cfg_i.debounce) begin
        steps_d     = steps_d + 32'd1;
        since_d     = '0;
        step_high_d = 1'b1;
        step_now    = 1'b1;
      end
    end else if (step_high_q && (mag_i < cfg_i.step_off)) begin
      step_high_d = 1'b0;
    end

    // Wrist-up on signed Y
    if (!wrist_q && ($signed(accel_y_i) > $signed(cfg_i.tilt_on))) begin
      wrist_d  = 1'b1;
      wake_now = 1'b1;
    end else if (wrist_q && ($signed(accel_y_i) < $signed(cfg_i.tilt_off))) begin
      wrist_d = 1'b0;
    end

    // Deviation from one g
    dev    = (mag_i >= OneG) ? mag_i - OneG : OneG - mag_i;
    moving = (dev > cfg_i.motion);

    // Still count, saturating; minutes advance with it
    if (dev < cfg_i.still) begin
      if (still_q != '1) begin
        still_d = still_q + 32'd1;
        if (sub_q == SubLast) begin
          sub_d  = '0;
          mins_d = mins_q + 23'd1;
        end else begin
          sub_d = sub_q + SubW'(1);
        end
      end
    end else begin
      still_d = '0;
      sub_d   = '0;
      mins_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_high_q <= 1'b0;
      wrist_q     <= 1'b0;
      steps_q     <= '0;
      since_q     <= '0;
      still_q     <= '0;
      sub_q       <= '0;
      mins_q      <= '0;
    end else if (commit_i) begin
      step_high_q <= step_high_d;
      wrist_q     <= wrist_d;
      steps_q     <= steps_d;
      since_q     <= since_d;
      still_q     <= still_d;
      sub_q       <= sub_d;
      mins_q      <= mins_d;
    end
  end

  assign res_o = '{
    step_total:       steps_d,
    step_seen:        step_now,
    wake_pulse:       wake_now,
    is_moving:        moving,
    inactive_samples: still_d,
    inactive_minutes: mins_d
  };

endmodule

`default_nettype wire

/* hdl/accel_step_tilt_activity_monitor.sv */
// ---------------------------------------------------------------------------
// accel_step_tilt_activity_monitor : pedometer, wrist-up and stillness monitor
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one request: a signed
//   Q3.12 three-axis sample plus a clear-steps bit. Output channel
//   (out_valid_o / out_stall_i) returns one result per request: step count,
//   step and wake flags, moving flag, still-sample count and still minutes.
//   A request passes from acceptance to the output register through
//   bit-serial squaring, a load of the sum, two-bit-per-step square root
//   and a commit, in that order. One request is in work at a time, so
//   the input stalls from acceptance on and reopens in the cycle after
//   commit; a new request is not taken before the last one is committed.
//   A finished result sits in the output register while the next request
//   is worked on; commit waits only if that register is still held by a
//   stalled receiver.
//   Configuration writes (cfg_we_i) take effect at once; indexes above the
//   register list are ignored. Reset loads the register defaults, clears
//   all trackers and empties the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module accel_step_tilt_activity_monitor #(
  parameter int unsigned SAMPLES_PER_MINUTE = atam_pkg::SamplesPerMinute
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          cfg_we_i,
  input  wire logic [atam_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [15:0]                   cfg_wdata_i,
  // input channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [15:0]            accel_x_i,
  input  wire logic signed [15:0]            accel_y_i,
  input  wire logic signed [15:0]            accel_z_i,
  input  wire logic                          clear_steps_i,
  // output channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [31:0]                        step_total_o,
  output logic                               step_seen_o,
  output logic                               wake_pulse_o,
  output logic                               is_moving_o,
  output logic [31:0]                        inactive_samples_o,
  output logic [22:0]                        inactive_minutes_o
);
  import atam_pkg::*;

  atam_state_e        state_q, state_d;
  atam_cfg_t          cfg_q;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic signed [15:0] y_q;
  logic               clear_q;
  logic               accept;
  logic               out_free;
  logic               sq_load, sq_step, rt_load, rt_step, commit;
  logic [31:0]        sq_x, sq_y, sq_z;
  logic [31:0]        sum_sq;
  logic [15:0]        mag;
  atam_res_t          res, res_q;
  logic               out_valid_q, out_valid_d;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_on  <= StepOnReset;
      cfg_q.step_off <= StepOffReset;
      cfg_q.tilt_on  <= TiltOnReset;
      cfg_q.tilt_off <= TiltOffReset;
      cfg_q.motion   <= MotionReset;
      cfg_q.still    <= StillReset;
      cfg_q.debounce <= DebounceReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegStepOn:   cfg_q.step_on  <= cfg_wdata_i;
        RegStepOff:  cfg_q.step_off <= cfg_wdata_i;
        RegTiltOn:   cfg_q.tilt_on  <= cfg_wdata_i;
        RegTiltOff:  cfg_q.tilt_off <= cfg_wdata_i;
        RegMotion:   cfg_q.motion   <= cfg_wdata_i;
        RegStill:    cfg_q.still    <= cfg_wdata_i;
        RegDebounce: cfg_q.debounce <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StIdle: begin
        cnt_d = '0;
        if (in_valid_i) state_d = StSquare;
      end
      StSquare: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(SerialSteps - 1)) state_d = StLoad;
      end
      StLoad: begin
        cnt_d   = '0;
        state_d = StRoot;
      end
      StRoot: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(SerialSteps - 1)) state_d = StCommit;
      end
      StCommit: begin
        if (out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_stall_o = 1'b1;
    sq_load    = 1'b0;
    sq_step    = 1'b0;
    rt_load    = 1'b0;
    rt_step    = 1'b0;
    commit     = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        sq_load    = in_valid_i;
      end
      StSquare: sq_step = 1'b1;
      StLoad:   rt_load = 1'b1;
      StRoot:   rt_step = 1'b1;
      StCommit: commit  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Request fields needed after the arithmetic
  always_ff @(posedge clk_i) begin
    if (accept) begin
      y_q     <= accel_y_i;
      clear_q <= clear_steps_i;
    end
  end

  // Squares of the three axes
  atam_sqr u_sqr_x (
    .clk_i    (clk_i),
    .load_i   (sq_load),
    .step_i   (sq_step),
    .operand_i(abs16(accel_x_i)),
    .square_o (sq_x)
  );

  atam_sqr u_sqr_y (
    .clk_i    (clk_i),
    .load_i   (sq_load),
    .step_i   (sq_step),
    .operand_i(abs16(accel_y_i)),
    .square_o (sq_y)
  );

  atam_sqr u_sqr_z (
    .clk_i    (clk_i),
    .load_i   (sq_load),
    .step_i   (sq_step),
    .operand_i(abs16(accel_z_i)),
    .square_o (sq_z)
  );

  // Each square is at most 2^30, so the sum stays within 32 bits
  assign sum_sq = sq_x + sq_y + sq_z;

  atam_isqrt u_isqrt (
    .clk_i     (clk_i),
    .load_i    (rt_load),
    .step_i    (rt_step),
    .radicand_i(sum_sq),
    .root_o    (mag)
  );

  atam_track #(
    .SAMPLES_PER_MINUTE(SAMPLES_PER_MINUTE)
  ) u_track (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .mag_i    (mag),
    .accel_y_i(y_q),
    .clear_i  (clear_q),
    .commit_i (commit),
    .res_o    (res)
  );

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) res_q <= res;
  end

  assign out_valid_o        = out_valid_q;
  assign step_total_o       = res_q.step_total;
  assign step_seen_o        = res_q.step_seen;
  assign wake_pulse_o       = res_q.wake_pulse;
  assign is_moving_o        = res_q.is_moving;
  assign inactive_samples_o = res_q.inactive_samples;
  assign inactive_minutes_o = res_q.inactive_minutes;

  // Checks
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("input not stalled after a request was taken");

  a_commit_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_o)
    else $error("committed result not presented");

  a_minutes_follow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && inactive_samples_o == 32'd0) |-> (inactive_minutes_o == 23'd0))
    else $error("minutes nonzero with no still samples");

endmodule

`default_nettype wire
